@@ rtl/spq_pkg.sv @@
// ============================================================================
// spq_pkg - shared types and codes of the sorted priority ready queue
// Command and response words, the entry held by each cell, the control word
// that reaches the cell chain, and the operation and status codes.
// ============================================================================
package spq_pkg;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned TASK_W  = 8;
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned COUNT_W = 5;

  // command word
  typedef struct packed {
    logic              operation;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
  } spq_cmd_t;

  // response word
  typedef struct packed {
    logic               popped_valid;
    logic [TASK_W-1:0]  popped_task;
    logic [PRIO_W-1:0]  popped_priority;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
  } spq_rsp_t;

  // one queue entry
  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
  } spq_entry_t;

  // chain control, broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } spq_ctrl_t;

endpackage

@@ rtl/spq_cell.sv @@
// ============================================================================
// spq_cell - one slot of the sorted queue chain
// Holds one entry. On insert it keeps its entry, takes the new one, or takes
// its left neighbour's entry to open a gap; on pop it takes the right one.
// ============================================================================
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  spq_ctrl_t  ctrl,
  input  logic       occupied,
  input  spq_entry_t new_entry,
  input  logic       left_greater,
  input  spq_entry_t left_entry,
  input  spq_entry_t right_entry,
  output logic       greater,
  output spq_entry_t entry
);

  // empty slots rank behind everything, so the new word lands there
  assign greater = !occupied || (entry.prio > new_entry.prio);

  // entry update: shift right on insert behind the gap, shift left on pop
  always_ff @(posedge clk) begin
    if (ctrl.ins && greater) begin
      entry <= left_greater ? left_entry : new_entry;
    end else if (ctrl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

@@ rtl/sorted_priority_ready_queue.sv @@
// Latency: a command taken at one edge gives its response word, with done
// high, in the cycle after; the chain accepts one command every cycle.
// Throughput is set by the cell chain: every cell compares and shifts in the
// same cycle, so busy stays low.
// Reset empties the queue (count cleared); entry contents are not cleared.
// The receiver cannot stall: each response is shown for one cycle only.
// ============================================================================
// sorted_priority_ready_queue - task ready queue kept sorted by priority
// A chain of QUEUE_DEPTH cells holds the entries in ascending priority, head
// in cell 0. Equal priorities leave first-in, first-out.
// ============================================================================
module sorted_priority_ready_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  spq_cmd_t cmd,
  output logic     done,
  output spq_rsp_t result
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic                     full;
  logic                     empty;
  logic                     take;
  spq_ctrl_t                ctrl;
  spq_entry_t               new_entry;
  spq_entry_t               cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_greater;
  logic [CW+COUNT_W-1:0]    count_ext;
  spq_rsp_t                 result_next;

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign full  = (count >= CW'(QUEUE_DEPTH));
  assign empty = (count == '0);

  // command decode into chain control
  always_comb begin
    ctrl.ins = take && (cmd.operation == OP_INSERT) && !full;
    ctrl.pop = take && (cmd.operation == OP_POP) && !empty;
  end

  assign new_entry.task_id = cmd.task_id;
  assign new_entry.prio    = cmd.priority_req;

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic       occ;
    logic       lg;
    spq_entry_t le;
    spq_entry_t re;

    assign occ = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign lg = 1'b0;
      assign le = new_entry;
    end else begin : g_body
      assign lg = cell_greater[i-1];
      assign le = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign re = cell_entry[i];
    end else begin : g_mid
      assign re = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occupied     (occ),
      .new_entry    (new_entry),
      .left_greater (lg),
      .left_entry   (le),
      .right_entry  (re),
      .greater      (cell_greater[i]),
      .entry        (cell_entry[i])
    );
  end

  // entry count
  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // response word, built from the head cell before the shift
  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  always_comb begin
    result_next.popped_valid    = ctrl.pop;
    result_next.popped_task     = ctrl.pop ? cell_entry[0].task_id : '0;
    result_next.popped_priority = ctrl.pop ? cell_entry[0].prio : '0;
    result_next.entry_count     = count_ext[COUNT_W-1:0];
    result_next.status          = ST_OK;
    if (cmd.operation == OP_INSERT && full) begin
      result_next.status = ST_FULL;
    end else if (cmd.operation == OP_POP && empty) begin
      result_next.status = ST_EMPTY;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule
